// ===== rtl/core/monotone_polygon_triangulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monotone polygon triangulator core.
// Shared concurrent assertion forms used by the core's datapath module.
// ----------------------------------------------------------------------------
`ifndef MONOTONE_POLYGON_TRIANGULATOR_CORE_ASSERT_SVH
`define MONOTONE_POLYGON_TRIANGULATOR_CORE_ASSERT_SVH

// The condition must never hold outside reset.
`define MPTC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mptc_pkg.sv =====
// ----------------------------------------------------------------------------
// mptc_pkg
// Types and constants shared by the monotone polygon triangulator modules.
// ----------------------------------------------------------------------------
package mptc_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = 6;
   localparam int CNT_W        = 7;
   localparam int COORD_W      = 32;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] apex_x;
      logic signed [COORD_W-1:0] apex_y;
      logic                      final_triangle;
   } triangle_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [IDX_W-1:0]          idx;
   } slot_type;

   typedef enum logic [4:0] {
      S_LOAD, S_RK_RDI, S_RK_LDI, S_RK_REQ, S_RK_CMP, S_RK_WR,
      S_SW_ST0, S_SW_ST1, S_F_SO, S_F_XY, S_F_CAP, S_DEC,
      S_CR_MAG, S_CR_P, S_CR_Q, S_CR_DEC, S_EMIT, S_EM_WAIT,
      S_POP, S_POP_CAP, S_FL_W0, S_FL_W1, S_PUSH, S_ADV
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_RK_RDI, OP_RK_LDI, OP_RK_REQ, OP_RK_CMP, OP_RK_WR,
      OP_SW_ST0, OP_SW_ST1, OP_F_SO, OP_F_XY, OP_F_CAP,
      OP_CR_MAG, OP_CR_P, OP_CR_Q, OP_EMIT, OP_POP, OP_POP_CAP,
      OP_FL_W0, OP_FL_W1, OP_PUSH, OP_ADV
   } op_type;

   typedef enum logic [2:0] {
      RET_INIT_B, RET_FETCH_I, RET_DEC, RET_EMIT, RET_CROSS, RET_ADV
   } ret_type;

   typedef enum logic [1:0] {
      SLOT_T, SLOT_B, SLOT_I
   } slot_sel_type;

   typedef enum logic [2:0] {
      PSEL_ZERO, PSEL_ONE, PSEL_I, PSEL_IM1, PSEL_BP
   } psel_type;

   typedef struct packed {
      op_type       op;
      slot_sel_type slot;
      psel_type     psel;
      logic         flush;
   } cmd_type;

   typedef struct packed {
      logic acc_last;
      logic poly_ok;
      logic j_end;
      logic i_end;
      logic flush;
      logic brk;
      logic pop_two;
      logic rsp_done;
   } status_type;

endpackage

// ===== rtl/core/monotone_polygon_triangulator_core.sv =====
// ----------------------------------------------------------------------------
// monotone_polygon_triangulator_core
// Triangulates an x-monotone polygon given as counterclockwise vertices.
// ----------------------------------------------------------------------------
// Vertices are taken one item per cycle until the item marked last; up to 64
// are kept and further ones are dropped. The vertices are then ranked by x
// with a stable order. The stack sweep follows and sends one triangle item
// per result, with the last triangle of the polygon flagged. The sweep waits
// on the result channel until each triangle is taken. No new vertex is taken
// until all n - 2 triangles have been delivered; a polygon of fewer than
// three vertices produces no result.
module monotone_polygon_triangulator_core import mptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  point_type    req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output triangle_type rsp_data
);

   cmd_type    cmd;
   status_type st;

   mptc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .st(st),
      .cmd(cmd)
   );

   mptc_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .st(st),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== rtl/core/mptc_ram.sv =====
// ----------------------------------------------------------------------------
// mptc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mptc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mptc_ctrl
// Sequencer for loading, ranking by x and the stack sweep of the triangulator.
// ----------------------------------------------------------------------------
module mptc_ctrl import mptc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type st,
   output cmd_type    cmd
);

   state_type    state_ff, state_in;
   ret_type      ret_ff, ret_in;
   slot_sel_type slot_ff, slot_in;
   psel_type     psel_ff, psel_in;
   logic         flush_ff, flush_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ret_ff   <= RET_DEC;
         slot_ff  <= SLOT_T;
         psel_ff  <= PSEL_ZERO;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         slot_ff  <= slot_in;
         psel_ff  <= psel_in;
         flush_ff <= flush_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      slot_in   = slot_ff;
      psel_in   = psel_ff;
      flush_in  = flush_ff;
      cmd.op    = OP_NONE;
      cmd.slot  = slot_ff;
      cmd.psel  = psel_ff;
      cmd.flush = flush_ff;
      case (state_ff)
         S_LOAD: begin
            cmd.op = OP_LOAD;
            if (st.acc_last && st.poly_ok) begin
               state_in = S_RK_RDI;
            end
         end
         S_RK_RDI: begin
            cmd.op   = OP_RK_RDI;
            state_in = S_RK_LDI;
         end
         S_RK_LDI: begin
            cmd.op   = OP_RK_LDI;
            state_in = S_RK_REQ;
         end
         S_RK_REQ: begin
            cmd.op   = OP_RK_REQ;
            state_in = S_RK_CMP;
         end
         S_RK_CMP: begin
            cmd.op   = OP_RK_CMP;
            state_in = st.j_end ? S_RK_WR : S_RK_REQ;
         end
         S_RK_WR: begin
            cmd.op   = OP_RK_WR;
            state_in = st.i_end ? S_SW_ST0 : S_RK_RDI;
         end
         S_SW_ST0: begin
            cmd.op   = OP_SW_ST0;
            state_in = S_SW_ST1;
         end
         S_SW_ST1: begin
            cmd.op   = OP_SW_ST1;
            psel_in  = PSEL_ONE;
            slot_in  = SLOT_T;
            ret_in   = RET_INIT_B;
            state_in = S_F_SO;
         end
         S_F_SO: begin
            cmd.op   = OP_F_SO;
            state_in = S_F_XY;
         end
         S_F_XY: begin
            cmd.op   = OP_F_XY;
            state_in = S_F_CAP;
         end
         S_F_CAP: begin
            cmd.op = OP_F_CAP;
            case (ret_ff)
               RET_INIT_B: begin
                  psel_in  = PSEL_ZERO;
                  slot_in  = SLOT_B;
                  ret_in   = RET_FETCH_I;
                  state_in = S_F_SO;
               end
               RET_FETCH_I: begin
                  psel_in  = PSEL_I;
                  slot_in  = SLOT_I;
                  ret_in   = RET_DEC;
                  state_in = S_F_SO;
               end
               RET_DEC:   state_in = S_DEC;
               RET_EMIT:  state_in = S_EMIT;
               RET_CROSS: state_in = S_CR_MAG;
               RET_ADV:   state_in = S_ADV;
               default:   state_in = S_LOAD;
            endcase
         end
         S_DEC: begin
            flush_in = st.flush;
            state_in = st.flush ? S_EMIT : S_CR_MAG;
         end
         S_CR_MAG: begin
            cmd.op   = OP_CR_MAG;
            state_in = S_CR_P;
         end
         S_CR_P: begin
            cmd.op   = OP_CR_P;
            state_in = S_CR_Q;
         end
         S_CR_Q: begin
            cmd.op   = OP_CR_Q;
            state_in = S_CR_DEC;
         end
         S_CR_DEC: begin
            state_in = st.brk ? S_PUSH : S_EMIT;
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = S_EM_WAIT;
         end
         S_EM_WAIT: begin
            if (st.rsp_done) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.op = OP_POP;
            if (st.pop_two) begin
               state_in = S_POP_CAP;
            end else begin
               state_in = flush_ff ? S_FL_W0 : S_PUSH;
            end
         end
         S_POP_CAP: begin
            cmd.op   = OP_POP_CAP;
            psel_in  = PSEL_BP;
            slot_in  = SLOT_B;
            ret_in   = flush_ff ? RET_EMIT : RET_CROSS;
            state_in = S_F_SO;
         end
         S_FL_W0: begin
            cmd.op   = OP_FL_W0;
            state_in = S_FL_W1;
         end
         S_FL_W1: begin
            cmd.op   = OP_FL_W1;
            psel_in  = PSEL_IM1;
            slot_in  = SLOT_B;
            ret_in   = RET_ADV;
            state_in = S_F_SO;
         end
         S_PUSH: begin
            cmd.op   = OP_PUSH;
            state_in = S_ADV;
         end
         S_ADV: begin
            cmd.op = OP_ADV;
            if (st.i_end) begin
               state_in = S_LOAD;
            end else begin
               psel_in  = PSEL_I;
               slot_in  = SLOT_I;
               ret_in   = RET_DEC;
               state_in = S_F_SO;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

endmodule

// ===== rtl/core/mptc_dpath.sv =====
// ----------------------------------------------------------------------------
// mptc_dpath
// Vertex stores, ranking counters, sweep stack, cross product unit and
// the result register of the triangulator.
// ----------------------------------------------------------------------------
`include "monotone_polygon_triangulator_core_assert.svh"

module mptc_dpath import mptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   st,
   input  logic         req_valid,
   output logic         req_ready,
   input  point_type    req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output triangle_type rsp_data
);

   function automatic logic chain_of(input logic [IDX_W-1:0] v, l, r);
      logic res;
      if (l < r) begin
         res = (v >= l) && (v <= r);
      end else begin
         res = (v >= l) || (v <= r);
      end
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] mag_of(input logic signed [COORD_W:0] d);
      logic [COORD_W:0] a;
      a = d[COORD_W] ? -d : d;
      return a[COORD_W-1:0];
   endfunction

   logic [CNT_W-1:0]          cnt_ff, cnt_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0]          sp_ff, sp_in;
   logic [IDX_W-1:0]          left_ff, left_in, right_ff, right_in;
   logic [IDX_W-1:0]          rank_ff, rank_in, tp_ff, tp_in, bp_ff, bp_in;
   logic [IDX_W-1:0]          fidx_ff, fidx_in, tri_ff, tri_in;
   logic signed [COORD_W-1:0] lx_ff, lx_in, rx_ff, rx_in, xi_ff, xi_in;
   slot_type                  ts_ff, ts_in, bs_ff, bs_in, is_ff, is_in;
   logic [COORD_W-1:0]        m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;
   logic                      n1_ff, n1_in, n2_ff, n2_in, n3_ff, n3_in, n4_ff, n4_in;
   logic [2*COORD_W-1:0]      p_ff, p_in, q_ff, q_in;
   logic                      s1_ff, s1_in, s2_ff, s2_in;
   triangle_type              rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      xy_we, s_we, k_we;
   logic [IDX_W-1:0]          xy_waddr, xy_raddr, s_waddr, s_raddr, k_waddr, k_raddr;
   logic [IDX_W-1:0]          s_wdata, k_wdata, s_rd, k_rd, pos_sel;
   logic [COORD_W-1:0]        x_rd, y_rd;

   logic                      req_fire;
   logic [CNT_W-1:0]          n_new, im1, sp_m3;
   logic signed [COORD_W:0]   d1, d2, d3, d4;
   logic signed [2*COORD_W+1:0] vp, vq, vdiff;
   logic                      c_pos, c_neg, ch_top;
   slot_type                  cap;

   mptc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_xram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr),
      .wr_data(req_data.point_x), .rd_addr(xy_raddr), .rd_data(x_rd)
   );

   mptc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_yram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr),
      .wr_data(req_data.point_y), .rd_addr(xy_raddr), .rd_data(y_rd)
   );

   mptc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_sram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr),
      .wr_data(s_wdata), .rd_addr(s_raddr), .rd_data(s_rd)
   );

   mptc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_kram (
      .clock(clock), .wr_en(k_we), .wr_addr(k_waddr),
      .wr_data(k_wdata), .rd_addr(k_raddr), .rd_data(k_rd)
   );

   assign req_ready = (cmd.op == OP_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign n_new     = cnt_ff[IDX_W] ? cnt_ff : cnt_ff + CNT_W'(1);
   assign im1       = i_ff - CNT_W'(1);
   assign sp_m3     = sp_ff - CNT_W'(3);

   assign d1 = {ts_ff.x[COORD_W-1], ts_ff.x} - {bs_ff.x[COORD_W-1], bs_ff.x};
   assign d2 = {is_ff.y[COORD_W-1], is_ff.y} - {bs_ff.y[COORD_W-1], bs_ff.y};
   assign d3 = {ts_ff.y[COORD_W-1], ts_ff.y} - {bs_ff.y[COORD_W-1], bs_ff.y};
   assign d4 = {is_ff.x[COORD_W-1], is_ff.x} - {bs_ff.x[COORD_W-1], bs_ff.x};

   assign vp     = s1_ff ? -$signed({2'b00, p_ff}) : $signed({2'b00, p_ff});
   assign vq     = s2_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
   assign vdiff  = vp - vq;
   assign c_neg  = vdiff[2*COORD_W+1];
   assign c_pos  = !c_neg && (vdiff != '0);
   assign ch_top = chain_of(ts_ff.idx, left_ff, right_ff);

   assign cap = '{x: x_rd, y: y_rd, idx: fidx_ff};

   always_comb begin
      case (cmd.psel)
         PSEL_ZERO: pos_sel = '0;
         PSEL_ONE:  pos_sel = IDX_W'(1);
         PSEL_I:    pos_sel = i_ff[IDX_W-1:0];
         PSEL_IM1:  pos_sel = im1[IDX_W-1:0];
         PSEL_BP:   pos_sel = bp_ff;
         default:   pos_sel = '0;
      endcase
   end

   always_comb begin
      st.acc_last = req_fire && req_data.last_point;
      st.poly_ok  = (n_new >= CNT_W'(3));
      st.j_end    = (j_ff == n_ff - CNT_W'(1));
      st.i_end    = (i_ff == n_ff - CNT_W'(1));
      st.flush    = st.i_end ||
                    (chain_of(is_ff.idx, left_ff, right_ff) != ch_top);
      st.brk      = (c_pos && !ch_top) || (c_neg && ch_top);
      st.pop_two  = (sp_ff >= CNT_W'(3));
      st.rsp_done = rsp_valid_ff && rsp_ready;
   end

   always_comb begin
      xy_we    = 1'b0;
      xy_waddr = cnt_ff[IDX_W-1:0];
      xy_raddr = '0;
      s_we     = 1'b0;
      s_waddr  = rank_ff;
      s_wdata  = i_ff[IDX_W-1:0];
      s_raddr  = pos_sel;
      k_we     = 1'b0;
      k_waddr  = '0;
      k_wdata  = '0;
      k_raddr  = sp_m3[IDX_W-1:0];
      case (cmd.op)
         OP_LOAD:   xy_we = req_fire && !cnt_ff[IDX_W];
         OP_RK_RDI: xy_raddr = i_ff[IDX_W-1:0];
         OP_RK_REQ: xy_raddr = j_ff[IDX_W-1:0];
         OP_RK_WR:  s_we = 1'b1;
         OP_F_XY:   xy_raddr = s_rd;
         OP_SW_ST0: k_we = 1'b1;
         OP_SW_ST1: begin
            k_we    = 1'b1;
            k_waddr = IDX_W'(1);
            k_wdata = IDX_W'(1);
         end
         OP_FL_W0: begin
            k_we    = 1'b1;
            k_wdata = im1[IDX_W-1:0];
         end
         OP_FL_W1: begin
            k_we    = 1'b1;
            k_waddr = IDX_W'(1);
            k_wdata = i_ff[IDX_W-1:0];
         end
         OP_PUSH: begin
            k_we    = 1'b1;
            k_waddr = sp_ff[IDX_W-1:0];
            k_wdata = i_ff[IDX_W-1:0];
         end
         default: xy_raddr = '0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;  n_in = n_ff;   i_in = i_ff;    j_in = j_ff;
      sp_in = sp_ff;    left_in = left_ff;  right_in = right_ff;
      rank_in = rank_ff;  tp_in = tp_ff;  bp_in = bp_ff;
      fidx_in = fidx_ff;  tri_in = tri_ff;
      lx_in = lx_ff;    rx_in = rx_ff;  xi_in = xi_ff;
      ts_in = ts_ff;    bs_in = bs_ff;  is_in = is_ff;
      m1_in = m1_ff;    m2_in = m2_ff;  m3_in = m3_ff;  m4_in = m4_ff;
      n1_in = n1_ff;    n2_in = n2_ff;  n3_in = n3_ff;  n4_in = n4_ff;
      p_in = p_ff;      q_in = q_ff;    s1_in = s1_ff;  s2_in = s2_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_LOAD: begin
            if (req_fire) begin
               if (!cnt_ff[IDX_W]) begin
                  if (cnt_ff == '0) begin
                     left_in  = '0;
                     right_in = '0;
                     lx_in    = req_data.point_x;
                     rx_in    = req_data.point_x;
                  end else begin
                     if (req_data.point_x < lx_ff) begin
                        left_in = cnt_ff[IDX_W-1:0];
                        lx_in   = req_data.point_x;
                     end
                     if (req_data.point_x > rx_ff) begin
                        right_in = cnt_ff[IDX_W-1:0];
                        rx_in    = req_data.point_x;
                     end
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_data.last_point) begin
                  cnt_in = '0;
                  n_in   = n_new;
                  i_in   = '0;
                  tri_in = '0;
               end
            end
         end
         OP_RK_LDI: begin
            xi_in   = $signed(x_rd);
            j_in    = '0;
            rank_in = '0;
         end
         OP_RK_CMP: begin
            if (($signed(x_rd) < xi_ff) || (($signed(x_rd) == xi_ff) && (j_ff < i_ff))) begin
               rank_in = rank_ff + IDX_W'(1);
            end
            j_in = j_ff + CNT_W'(1);
         end
         OP_RK_WR:  i_in = i_ff + CNT_W'(1);
         OP_SW_ST1: begin
            sp_in = CNT_W'(2);
            tp_in = IDX_W'(1);
            bp_in = '0;
            i_in  = CNT_W'(2);
         end
         OP_F_XY: fidx_in = s_rd;
         OP_F_CAP: begin
            case (cmd.slot)
               SLOT_T:  ts_in = cap;
               SLOT_B:  bs_in = cap;
               SLOT_I:  is_in = cap;
               default: is_in = cap;
            endcase
         end
         OP_CR_MAG: begin
            m1_in = mag_of(d1);  n1_in = d1[COORD_W];
            m2_in = mag_of(d2);  n2_in = d2[COORD_W];
            m3_in = mag_of(d3);  n3_in = d3[COORD_W];
            m4_in = mag_of(d4);  n4_in = d4[COORD_W];
         end
         OP_CR_P: begin
            p_in  = m1_ff * m2_ff;
            s1_in = (p_in != '0) && (n1_ff != n2_ff);
         end
         OP_CR_Q: begin
            q_in  = m3_ff * m4_ff;
            s2_in = (q_in != '0) && (n3_ff != n4_ff);
         end
         OP_EMIT: begin
            if (cmd.flush) begin
               rsp_in.first_x  = ts_ff.x;
               rsp_in.first_y  = ts_ff.y;
               rsp_in.second_x = bs_ff.x;
               rsp_in.second_y = bs_ff.y;
            end else begin
               rsp_in.first_x  = bs_ff.x;
               rsp_in.first_y  = bs_ff.y;
               rsp_in.second_x = ts_ff.x;
               rsp_in.second_y = ts_ff.y;
            end
            rsp_in.apex_x         = is_ff.x;
            rsp_in.apex_y         = is_ff.y;
            rsp_in.final_triangle = ({1'b0, tri_ff} == n_ff - CNT_W'(3));
            tri_in       = tri_ff + IDX_W'(1);
            rsp_valid_in = 1'b1;
         end
         OP_POP: begin
            ts_in = bs_ff;
            tp_in = bp_ff;
            sp_in = sp_ff - CNT_W'(1);
         end
         OP_POP_CAP: bp_in = k_rd;
         OP_FL_W1: begin
            sp_in = CNT_W'(2);
            tp_in = i_ff[IDX_W-1:0];
            bp_in = im1[IDX_W-1:0];
            ts_in = is_ff;
         end
         OP_PUSH: begin
            sp_in = sp_ff + CNT_W'(1);
            bp_in = tp_ff;
            bs_in = ts_ff;
            tp_in = i_ff[IDX_W-1:0];
            ts_in = is_ff;
         end
         OP_ADV: i_in = i_ff + CNT_W'(1);
         default: i_in = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         sp_ff        <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         rank_ff      <= '0;
         tri_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         sp_ff        <= sp_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rank_ff      <= rank_in;
         tri_ff       <= tri_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tp_ff   <= tp_in;
      bp_ff   <= bp_in;
      fidx_ff <= fidx_in;
      lx_ff   <= lx_in;
      rx_ff   <= rx_in;
      xi_ff   <= xi_in;
      ts_ff   <= ts_in;
      bs_ff   <= bs_in;
      is_ff   <= is_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      m3_ff   <= m3_in;
      m4_ff   <= m4_in;
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      n3_ff   <= n3_in;
      n4_ff   <= n4_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MPTC_ASSERT_NEVER(a_sp_range, clock, reset, sp_ff > CNT_W'(MAX_VERTICES), "stack overflow")
   `MPTC_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CNT_W'(MAX_VERTICES), "count overflow")
   `MPTC_ASSERT_NEVER(a_load_quiet, clock, reset, req_ready && rsp_valid_ff, "item pending in load")
   `MPTC_ASSERT_NEXT(a_emit, clock, reset, cmd.op == OP_EMIT, rsp_valid_ff && (rsp_ff.apex_x == $past(is_ff.x)), "emit lost")

endmodule
